[hdl/kplock_pkg.sv]
// ----------------------------------------------------------------------------
// kplock_pkg - shared types and constants for the keypad PIN lock
// Key codes, mode and status encodings, PIN length and default PIN.
// ----------------------------------------------------------------------------
package kplock_pkg;

  // number of keys in one PIN
  localparam int PIN_LENGTH = 4;
  localparam int CNT_W      = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PIN_LENGTH - 1);

  // keypad codes
  localparam logic [7:0] KEY_STAR = 8'd42;
  localparam logic [7:0] KEY_HASH = 8'd35;

  // default pin, repeated for longer pins
  localparam logic [7:0] PIN_DEFAULT [4] = '{8'h36, 8'h35, 8'h34, 8'h35};

  typedef enum logic [2:0] {
    MODE_MENU    = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_OLD     = 3'd2,
    MODE_NEW     = 3'd3,
    MODE_GRANTED = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_IGNORED   = 4'd0,
    ST_ENTER     = 4'd1,
    ST_DIGIT     = 4'd2,
    ST_GRANTED   = 4'd3,
    ST_DENIED    = 4'd4,
    ST_LOCKED    = 4'd5,
    ST_ENTER_NEW = 4'd6,
    ST_SAVED     = 4'd7,
    ST_TRY_AGAIN = 4'd8
  } status_t;

endpackage

[hdl/keypad_pin_lock_controller.sv]
// ----------------------------------------------------------------------------
// keypad_pin_lock_controller - four-key PIN lock driven by keypad codes
// Opens the relay on a matching PIN, latches an alarm on a wrong opening PIN and
// supports changing the stored PIN after the old one is entered.
// ----------------------------------------------------------------------------
// Each accepted key item's result item is registered and offered in the cycle after the key is taken.
// Throughput: one item per cycle while the output side is not stalled; the mode
// update and PIN compare both complete in the cycle the key is taken, and one
// result register decouples the output side.
// Reset (rst, synchronous): menu mode, relay and LEDs off, alarm clear,
// stored PIN back to 6545; the entry buffer is not cleared.
// ----------------------------------------------------------------------------
module keypad_pin_lock_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] echo_key, [8] relay_on, [9] grant_led,
                                      // [10] deny_led, [11] alarm, [15:12] zero
  output logic [3:0]  m_axis_tuser    // [3:0] status
);
  import kplock_pkg::*;

  // state
  mode_t            mode, mode_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic [7:0]       entry_buffer [PIN_LENGTH];
  logic [7:0]       stored_pin   [PIN_LENGTH];
  logic             relay_reg, relay_next;
  logic             grant_led_reg, grant_led_next;
  logic             deny_led_reg, deny_led_next;
  logic             alarm_reg, alarm_next;

  // result register
  logic             out_valid;
  status_t          out_status;
  logic [7:0]       out_echo;

  // per-item decode
  logic             accept;
  logic             take;
  logic             commit;
  logic             last;
  logic             match;
  status_t          status_next;
  logic [7:0]       echo_next;
  logic [7:0]       entry_full [PIN_LENGTH];

  assign s_axis_tready = !rst && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last          = (digit_count == LAST_IDX);

  // completed entry: buffer with the current key in its slot
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PIN_LENGTH; i++) begin
      entry_full[i] = (CNT_W'(i) == digit_count) ? s_axis_tdata : entry_buffer[i];
      if (entry_full[i] != stored_pin[i]) begin
        match = 1'b0;
      end
    end
  end

  // next mode, flags and result
  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    relay_next       = relay_reg;
    grant_led_next   = grant_led_reg;
    deny_led_next    = deny_led_reg;
    alarm_next       = alarm_reg;
    take             = 1'b0;
    commit           = 1'b0;
    status_next      = ST_IGNORED;
    echo_next        = 8'd0;
    case (mode)
      MODE_OPEN, MODE_OLD, MODE_NEW: begin
        take = 1'b1;
        if (last) begin
          digit_count_next = '0;
          if (mode == MODE_NEW) begin
            commit      = 1'b1;
            mode_next   = MODE_MENU;
            status_next = ST_SAVED;
          end else if (match) begin
            if (mode == MODE_OPEN) begin
              relay_next     = 1'b1;
              grant_led_next = 1'b1;
              deny_led_next  = 1'b0;
              mode_next      = MODE_GRANTED;
              status_next    = ST_GRANTED;
            end else begin
              mode_next   = MODE_NEW;
              status_next = ST_ENTER_NEW;
            end
          end else begin
            deny_led_next  = 1'b1;
            grant_led_next = 1'b0;
            mode_next      = MODE_MENU;
            if (mode == MODE_OPEN) begin
              alarm_next  = 1'b1;
              status_next = ST_DENIED;
            end else begin
              status_next = ST_TRY_AGAIN;
            end
          end
        end else begin
          digit_count_next = digit_count + 1'b1;
          status_next      = ST_DIGIT;
          echo_next        = s_axis_tdata;
        end
      end
      MODE_GRANTED: begin
        if (s_axis_tdata == KEY_HASH) begin
          relay_next     = 1'b0;
          grant_led_next = 1'b1;
          mode_next      = MODE_MENU;
          status_next    = ST_LOCKED;
        end
      end
      default: begin
        mode_next        = MODE_MENU;
        digit_count_next = '0;
        if (s_axis_tdata == KEY_STAR) begin
          mode_next   = MODE_OPEN;
          status_next = ST_ENTER;
        end else if (s_axis_tdata == KEY_HASH) begin
          mode_next   = MODE_OLD;
          status_next = ST_ENTER;
        end
      end
    endcase
  end

  // control state and stored pin
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_MENU;
      digit_count   <= '0;
      relay_reg     <= 1'b0;
      grant_led_reg <= 1'b0;
      deny_led_reg  <= 1'b0;
      alarm_reg     <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < PIN_LENGTH; i++) begin
        stored_pin[i] <= PIN_DEFAULT[i % 4];
      end
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        mode          <= mode_next;
        digit_count   <= digit_count_next;
        relay_reg     <= relay_next;
        grant_led_reg <= grant_led_next;
        deny_led_reg  <= deny_led_next;
        alarm_reg     <= alarm_next;
        out_valid     <= 1'b1;
        if (commit) begin
          for (int i = 0; i < PIN_LENGTH; i++) begin
            stored_pin[i] <= entry_full[i];
          end
        end
      end
    end
  end

  // entry buffer and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_echo   <= echo_next;
      if (take) begin
        entry_buffer[digit_count] <= s_axis_tdata;
      end
    end
  end

  // flags show the registers after the item held in the result register
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {4'd0, alarm_reg, deny_led_reg, grant_led_reg, relay_reg, out_echo};

endmodule
